FILE: hdl/sghm_pkg.sv
// shared types and constants for the sparse grid hash map
package sghm_pkg;
  localparam int unsigned HASH_ROUNDS = 12;
  localparam int unsigned MIX_SHIFT = 8;
  localparam logic [63:0] MIX_MULT = 64'h6B;
  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam int unsigned ROUND_BITS = 4;
  localparam int unsigned DATA_BYTES = 14;
  localparam int unsigned OUT_BYTES = 2;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_HASH  = 7'b0000010,
    ST_COMB  = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_CMP   = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic combine;
    logic way_read;
    logic way_check;
    logic commit;
    logic out_load;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic ways_done;
    logic stop_scan;
    logic clear_done;
  } stat_t;
endpackage

FILE: hdl/sghm_ram.sv
// generic single-port-write ram with registered read
module sghm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/sghm_ctrl.sv
// control state machine for the hash map
module sghm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_busy,
  input  sghm_pkg::stat_t   stat,
  output sghm_pkg::cmd_t    cmd
);
  sghm_pkg::state_t state_r, state_nxt;
  logic clearing_r, clearing_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sghm_pkg::ST_IDLE;
      clearing_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  assign in_tready = (state_r == sghm_pkg::ST_IDLE) && !clearing_r;

  always_comb begin
    state_nxt    = state_r;
    clearing_nxt = clearing_r && !stat.clear_done;
    cmd          = '0;
    cmd.clear_step = clearing_r;
    unique case (state_r)
      sghm_pkg::ST_IDLE: begin
        if (in_tvalid && !clearing_r) begin
          cmd.load  = 1'b1;
          state_nxt = sghm_pkg::ST_HASH;
        end
      end
      sghm_pkg::ST_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_done) begin
          state_nxt = sghm_pkg::ST_COMB;
        end
      end
      sghm_pkg::ST_COMB: begin
        cmd.combine = 1'b1;
        state_nxt   = sghm_pkg::ST_READ;
      end
      sghm_pkg::ST_READ: begin
        cmd.way_read = 1'b1;
        state_nxt    = sghm_pkg::ST_CMP;
      end
      sghm_pkg::ST_CMP: begin
        cmd.way_check = 1'b1;
        if (stat.ways_done || stat.stop_scan) begin
          state_nxt = sghm_pkg::ST_WRITE;
        end else begin
          state_nxt = sghm_pkg::ST_READ;
        end
      end
      sghm_pkg::ST_WRITE: begin
        if (!out_busy) begin
          cmd.commit   = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt    = sghm_pkg::ST_IDLE;
        end
      end
      sghm_pkg::ST_OUT: state_nxt = sghm_pkg::ST_IDLE;
      default: state_nxt = sghm_pkg::ST_IDLE;
    endcase
  end
endmodule

FILE: hdl/sghm_dp.sv
// datapath: coordinate hashing, bucket scan and table storage
module sghm_dp #(
  parameter int INDEX_BITS = 12,
  parameter int WAYS = 4,
  parameter int COORD_BITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sghm_pkg::cmd_t  cmd,
  output sghm_pkg::stat_t stat,
  input  logic            action,
  input  logic [31:0]     coord_x,
  input  logic [31:0]     coord_y,
  input  logic [31:0]     coord_z,
  input  logic [7:0]      new_char,
  output logic [7:0]      res_char,
  output logic            res_found,
  output logic            res_full
);
  localparam int ENTRIES = (1 << INDEX_BITS) * WAYS;
  localparam int ADDR_BITS = $clog2(ENTRIES);
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KB = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int VBITS = 1 + 3 * KB + 8;

  logic [63:0] hx_r, hy_r, hz_r;
  logic [sghm_pkg::ROUND_BITS-1:0] round_r;
  logic [INDEX_BITS-1:0] bucket_r;
  logic [KB-1:0] kx_r, ky_r, kz_r;
  logic [7:0] ch_r;
  logic act_r;
  logic [WAY_BITS:0] way_r;
  logic hit_r, free_r;
  logic [WAY_BITS-1:0] hit_way_r, free_way_r;
  logic [7:0] hit_char_r;
  logic [ADDR_BITS:0] clr_r;

  logic [VBITS-1:0] rd;
  logic [ADDR_BITS-1:0] scan_addr, wr_addr;
  logic we;
  logic [VBITS-1:0] wdata;
  logic [63:0] fx, fy, fz, hsum;
  logic rv;
  logic [KB-1:0] rx, ry, rz;
  logic [7:0] rc;
  logic match;

  function automatic logic [63:0] mix(input logic [63:0] v,
                                      input logic [sghm_pkg::ROUND_BITS-1:0] r);
    mix = ((v >> sghm_pkg::MIX_SHIFT) ^ v) * sghm_pkg::MIX_MULT + 64'(r);
  endfunction

  assign fx = mix(hx_r, round_r);
  assign fy = mix(hy_r, round_r);
  assign fz = mix(hz_r, round_r);
  assign hsum = hy_r + hz_r;

  assign scan_addr = ADDR_BITS'(bucket_r) * ADDR_BITS'(WAYS) + ADDR_BITS'(way_r);
  assign {rv, rx, ry, rz, rc} = rd;
  assign match = rv && rx == kx_r && ry == ky_r && rz == kz_r;

  always_comb begin
    we    = 1'b0;
    wr_addr = clr_r[ADDR_BITS-1:0];
    wdata = '0;
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.commit && act_r && (hit_r || free_r)) begin
      we = 1'b1;
      wr_addr = ADDR_BITS'(bucket_r) * ADDR_BITS'(WAYS)
                + ADDR_BITS'(hit_r ? hit_way_r : free_way_r);
      wdata = {1'b1, kx_r, ky_r, kz_r, ch_r};
    end
  end

  sghm_ram #(.WIDTH(VBITS), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(wr_addr), .wdata(wdata),
    .raddr(scan_addr),
    .rdata(rd)
  );

  assign stat.hash_done  = round_r == sghm_pkg::ROUND_BITS'(sghm_pkg::HASH_ROUNDS - 1);
  assign stat.ways_done  = way_r == (WAY_BITS+1)'(WAYS - 1);
  assign stat.stop_scan  = match;
  assign stat.clear_done = clr_r == (ADDR_BITS+1)'(ENTRIES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_r <= clr_r + 1'b1;
    end
    if (cmd.load) begin
      kx_r <= coord_x[KB-1:0];
      ky_r <= coord_y[KB-1:0];
      kz_r <= coord_z[KB-1:0];
      hx_r <= 64'(coord_x[KB-1:0]);
      hy_r <= 64'(coord_y[KB-1:0]);
      hz_r <= 64'(coord_z[KB-1:0]);
      ch_r <= new_char;
      act_r <= action;
      round_r <= '0;
    end
    if (cmd.hash_step) begin
      hx_r <= fx;
      hy_r <= fy;
      hz_r <= fz;
      round_r <= round_r + 1'b1;
    end
    if (cmd.combine) begin
      bucket_r <= INDEX_BITS'((hx_r & hsum) & 64'hFFFF);
      way_r <= '0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
    end
    if (cmd.way_check) begin
      if (match) begin
        hit_r <= 1'b1;
        hit_way_r <= way_r[WAY_BITS-1:0];
        hit_char_r <= rc;
      end else if (!rv && !free_r) begin
        free_r <= 1'b1;
        free_way_r <= way_r[WAY_BITS-1:0];
      end
      way_r <= way_r + 1'b1;
    end
    if (cmd.out_load) begin
      res_found <= hit_r;
      res_full  <= act_r && !hit_r && !free_r;
      res_char  <= act_r ? ch_r : (hit_r ? hit_char_r : sghm_pkg::SPACE_CHAR);
    end
  end
endmodule

FILE: hdl/sparse_grid_hash_map_top.sv
// top level of the sparse grid hash map
// Each beat passes through the accept state, twelve hash rounds on three parallel mixers,
// a combine step, a registered ram read and a compare for each way scanned (the scan stops
// at a hit), and a write state that also loads the result and waits while the output is busy.
// After reset a clearing pass writes every table entry empty while in_tready is low.
module sparse_grid_hash_map_top #(
  parameter int INDEX_BITS = 12,
  parameter int WAYS = 4,
  parameter int COORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // action, coord_x, coord_y, coord_z, new_char, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata  // result_char, found, bucket_full, zero pad
);
  sghm_pkg::cmd_t cmd;
  sghm_pkg::stat_t stat;
  logic out_valid_r;
  logic [7:0] res_char;
  logic res_found, res_full;

  sghm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_busy(out_valid_r && !out_tready), .stat(stat), .cmd(cmd)
  );

  sghm_dp #(.INDEX_BITS(INDEX_BITS), .WAYS(WAYS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .action(in_tdata[0]), .coord_x(in_tdata[32:1]), .coord_y(in_tdata[64:33]),
    .coord_z(in_tdata[96:65]), .new_char(in_tdata[104:97]),
    .res_char(res_char), .res_found(res_found), .res_full(res_full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_full, res_found, res_char};

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !cmd.out_load) else $error("result overwritten");
  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[8] && out_tdata[9])) else $error("found and full");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.hash_step, cmd.combine, cmd.way_read, cmd.way_check,
              cmd.commit})) else $error("overlapping commands");
`endif
endmodule

FILE: tb/sparse_grid_hash_map_top_tb.sv
// self-checking testbench for the sparse grid hash map top level
module sparse_grid_hash_map_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INDEX_BITS = 12;
  localparam int WAYS = 4;
  localparam int COORD_BITS = 32;
  localparam int N_BUCKETS = 1 << INDEX_BITS;
  localparam int N_ENTRIES = N_BUCKETS * WAYS;
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_PLACE = 1'b1;
  localparam int N_RANDOM = 1130;

  typedef struct packed {
    logic [7:0]  ch;
    logic        found;
    logic        full;
  } grid_result_t;

  typedef struct {
    logic        act;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  ch;
    logic        has_fixed;
    grid_result_t fixed;
  } grid_req_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;

  // predictor copy of the table
  logic        tbl_valid [N_ENTRIES];
  logic [31:0] tbl_x [N_ENTRIES];
  logic [31:0] tbl_y [N_ENTRIES];
  logic [31:0] tbl_z [N_ENTRIES];
  logic [7:0]  tbl_ch [N_ENTRIES];

  grid_result_t pending_results[$];
  grid_req_t    directed_rows[$];
  int           n_errors = 0;
  int           n_results = 0;
  int           n_sent = 0;
  int           n_full_seen = 0;
  int           n_hits_seen = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  bit           rx_hold = 0;
  logic [31:0]  pool_x [16];
  logic [31:0]  pool_y [16];
  logic [31:0]  pool_z [16];

  sparse_grid_hash_map_top #(
    .INDEX_BITS(INDEX_BITS), .WAYS(WAYS), .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] mix_coord(input logic [63:0] v);
    logic [63:0] h;
    h = v;
    for (int r = 0; r < 12; r++) begin
      h = ((h >> 8) ^ h) * 64'h6B + 64'(r);
    end
    return h;
  endfunction

  function automatic int bucket_index(input logic [31:0] x, y, z);
    logic [63:0] h;
    h = mix_coord({32'd0, x}) & (mix_coord({32'd0, y}) + mix_coord({32'd0, z}));
    return int'(h[15:0]) & (N_BUCKETS - 1);
  endfunction

  function automatic grid_result_t grid_access(input grid_req_t q);
    grid_result_t res;
    int base;
    int hit;
    int free_way;
    base = bucket_index(q.x, q.y, q.z) * WAYS;
    hit = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (tbl_valid[base + w]) begin
        if (hit < 0 && tbl_x[base + w] == q.x && tbl_y[base + w] == q.y
            && tbl_z[base + w] == q.z) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    res.found = (hit >= 0);
    res.full = 1'b0;
    if (q.act == ACT_LOOKUP) begin
      res.ch = (hit >= 0) ? tbl_ch[base + hit] : sghm_pkg::SPACE_CHAR;
      return res;
    end
    res.ch = q.ch;
    if (hit >= 0) begin
      tbl_ch[base + hit] = q.ch;
    end else if (free_way >= 0) begin
      tbl_valid[base + free_way] = 1'b1;
      tbl_x[base + free_way] = q.x;
      tbl_y[base + free_way] = q.y;
      tbl_z[base + free_way] = q.z;
      tbl_ch[base + free_way] = q.ch;
    end else begin
      res.full = 1'b1;
    end
    return res;
  endfunction

  // tvalid stays high after a beat unless an idle cycle follows
  task automatic send_request(input grid_req_t q);
    grid_result_t want;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, q.ch, q.z, q.y, q.x, q.act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = grid_access(q);
    if (q.has_fixed && want != q.fixed) begin
      $display("%0t predictor disagrees with table row: expected %h, predicted %h",
               $time, q.fixed, want);
      n_errors++;
    end
    pending_results.push_back(want);
    n_sent++;
  endtask

  function automatic grid_req_t make_req(input logic act, input logic [31:0] x, y, z,
                                         input logic [7:0] ch, input bit fx,
                                         input grid_result_t fr);
    grid_req_t q;
    q.act = act; q.x = x; q.y = y; q.z = z; q.ch = ch;
    q.has_fixed = fx; q.fixed = fr;
    return q;
  endfunction

  // find a coordinate set that lands in the given bucket
  task automatic same_bucket(input int b, output logic [31:0] x, y, z);
    do begin
      x = $urandom_range(4095); y = $urandom; z = $urandom;
    end while (bucket_index(x, y, z) != b);
  endtask

  // receiver
  always @(posedge clk) begin
    grid_result_t got;
    grid_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = grid_result_t'({out_tdata[7:0], out_tdata[8], out_tdata[9]});
        if (out_tdata[15:10] != 6'd0) begin
          $display("%0t pad bits: expected 0, actual %h", $time, out_tdata[15:10]);
          n_errors++;
        end
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, got);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          n_results++;
          n_full_seen += got.full;
          n_hits_seen += got.found;
          if (got.ch !== want.ch)
            $display("%0t result_char: expected %h, actual %h", $time, want.ch, got.ch);
          if (got.found !== want.found)
            $display("%0t found: expected %b, actual %b", $time, want.found, got.found);
          if (got.full !== want.full)
            $display("%0t bucket_full: expected %b, actual %b", $time, want.full, got.full);
          if (got !== want) n_errors++;
        end
      end
      out_tready <= !rx_hold && !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
    end else begin
      out_tready <= 1'b0;
    end
  end

  initial begin
    #400ms;
    $display("sparse_grid_hash_map_top_tb: done, errors");
    $finish;
  end

  initial begin
    grid_req_t q;
    grid_result_t r;
    logic [31:0] x, y, z;
    logic [31:0] bx [WAYS + 1];
    logic [31:0] by [WAYS + 1];
    logic [31:0] bz [WAYS + 1];
    int k;
    int drain;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    for (int e = 0; e < N_ENTRIES; e++) tbl_valid[e] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: empty lookups, extremes, overwrite, then a full bucket
    r = '{ch: sghm_pkg::SPACE_CHAR, found: 1'b0, full: 1'b0};
    directed_rows.push_back(make_req(ACT_LOOKUP, 0, 0, 0, 8'hFF, 1, r));
    directed_rows.push_back(make_req(ACT_LOOKUP, '1, '1, '1, 8'h00, 1, r));
    r = '{ch: 8'h00, found: 1'b0, full: 1'b0};
    directed_rows.push_back(make_req(ACT_PLACE, 0, 0, 0, 8'h00, 1, r));
    r = '{ch: 8'hFF, found: 1'b0, full: 1'b0};
    directed_rows.push_back(make_req(ACT_PLACE, '1, '1, '1, 8'hFF, 1, r));
    r = '{ch: 8'h00, found: 1'b1, full: 1'b0};
    directed_rows.push_back(make_req(ACT_LOOKUP, 0, 0, 0, 8'h55, 1, r));
    r = '{ch: 8'hFF, found: 1'b1, full: 1'b0};
    directed_rows.push_back(make_req(ACT_LOOKUP, '1, '1, '1, 8'h00, 1, r));
    r = '{ch: 8'hA5, found: 1'b1, full: 1'b0};
    directed_rows.push_back(make_req(ACT_PLACE, 0, 0, 0, 8'hA5, 1, r));
    directed_rows.push_back(make_req(ACT_LOOKUP, 0, 0, 0, 8'h00, 1, r));
    directed_rows.push_back(make_req(ACT_LOOKUP, 32'h8000_0000, 1, 32'h7FFF_FFFF, 0, 0, r));
    // the crowded bucket must stay clear of the two corner positions placed above
    bx[0] = 7; by[0] = 9; bz[0] = 11;
    while (bucket_index(bx[0], by[0], bz[0]) == bucket_index(0, 0, 0)
           || bucket_index(bx[0], by[0], bz[0]) == bucket_index('1, '1, '1)) bx[0]++;
    k = bucket_index(bx[0], by[0], bz[0]);
    for (int i = 1; i <= WAYS; i++) same_bucket(k, bx[i], by[i], bz[i]);
    for (int i = 0; i < WAYS; i++) begin
      r = '{ch: 8'(8'h41 + i), found: 1'b0, full: 1'b0};
      directed_rows.push_back(make_req(ACT_PLACE, bx[i], by[i], bz[i], r.ch, 1, r));
    end
    r = '{ch: 8'h5A, found: 1'b0, full: 1'b1};
    directed_rows.push_back(make_req(ACT_PLACE, bx[WAYS], by[WAYS], bz[WAYS], 8'h5A, 1, r));
    r = '{ch: sghm_pkg::SPACE_CHAR, found: 1'b0, full: 1'b0};
    directed_rows.push_back(make_req(ACT_LOOKUP, bx[WAYS], by[WAYS], bz[WAYS], 0, 1, r));
    r = '{ch: 8'h7E, found: 1'b1, full: 1'b0};
    directed_rows.push_back(make_req(ACT_PLACE, bx[2], by[2], bz[2], 8'h7E, 1, r));
    r = '{ch: 8'h42, found: 1'b1, full: 1'b0};
    directed_rows.push_back(make_req(ACT_LOOKUP, bx[1], by[1], bz[1], 8'hC3, 1, r));
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    for (int i = 0; i < 16; i++) begin
      pool_x[i] = $urandom; pool_y[i] = $urandom; pool_z[i] = $urandom;
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      // phases of idling
      case (n * 5 / N_RANDOM)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        3: begin tx_idle_pct = 9;  rx_stall_pct = 9;  end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      if (n == 300) begin
        // long receiver hold-off while the sender keeps offering beats
        fork
          begin
            rx_hold = 1;
            repeat (400) @(posedge clk);
            rx_hold = 0;
          end
        join_none
      end
      if (n == 700) begin
        // sender pauses until the pipeline drains
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      k = $urandom_range(99);
      if (k < 60) begin
        k = $urandom_range(15);
        x = pool_x[k]; y = pool_y[k]; z = pool_z[k];
      end else if (k < 80) begin
        // crowd a handful of buckets so they fill up
        same_bucket($urandom_range(3), x, y, z);
      end else if (k < 90) begin
        x = $urandom_range(1) ? '1 : 0; y = $urandom_range(1) ? '1 : 0;
        z = $urandom_range(1) ? '1 : 0;
      end else begin
        x = $urandom; y = $urandom; z = $urandom;
      end
      q = make_req(logic'($urandom_range(1)), x, y, z, 8'($urandom), 0, r);
      send_request(q);
    end
    in_tvalid <= 1'b0;
    rx_stall_pct = 0;

    drain = 0;
    while (pending_results.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t %0d results never arrived", $time, pending_results.size());
      n_errors++;
    end
    $display("covered %0d requests, %0d results, %0d hits, %0d full-bucket drops",
             n_sent, n_results, n_hits_seen, n_full_seen);
    $display("idle phases: none, sender, receiver, both, plus long hold-off and drain");
    if (n_errors == 0) begin
      $display("sparse_grid_hash_map_top_tb: done, clean");
    end else begin
      $display("sparse_grid_hash_map_top_tb: done, errors");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/sghm_pkg.sv
hdl/sghm_ram.sv
hdl/sghm_ctrl.sv
hdl/sghm_dp.sv
hdl/sparse_grid_hash_map_top.sv
tb/sparse_grid_hash_map_top_tb.sv
